// ===== rtl/dew_pkg.sv =====
// Package for the disk erosion window: sizes, configuration, command and
// status types shared by the controller, the datapath and the top level.
// Depends on nothing.
`default_nettype none
package dew_pkg;

    localparam int MAX_RADIUS = 7;
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    // Ring of rows in the line store; a power of two so the row index is a bit slice.
    localparam int LINE_ROWS  = 2 * MAX_RADIUS + 2;

    localparam int COL_BITS   = $clog2(MAX_WIDTH);
    localparam int ROW_BITS   = $clog2(MAX_HEIGHT);
    localparam int RING_BITS  = $clog2(LINE_ROWS);
    localparam int ADDR_BITS  = RING_BITS + COL_BITS;
    localparam int DEPTH      = LINE_ROWS * MAX_WIDTH;

    // Register indexes of the configuration port.
    localparam logic [1:0] REG_RADIUS    = 2'd0;
    localparam logic [1:0] REG_ZERO_FILL = 2'd1;
    localparam logic [1:0] REG_WIDTH     = 2'd2;
    localparam logic [1:0] REG_HEIGHT    = 2'd3;

    typedef struct packed {
        logic [2:0]  radius;
        logic        zero_fill;
        logic [10:0] width;   // effective, 1..MAX_WIDTH
        logic [10:0] height;  // effective, 1..MAX_HEIGHT
    } t_cfg;

    typedef struct packed {
        logic store;      // take the accepted word into the line store
        logic scan_init;  // start a window scan
        logic scan_step;  // issue one window read
        logic emit;       // load the output register
    } t_cmd;

    typedef struct packed {
        logic win_ready;  // every input the next output needs is stored
        logic scan_last;  // the scan position is the last of the window
        logic out_free;   // the output register can take a word
    } t_stat;

endpackage
`default_nettype wire

// ===== rtl/dew_ctrl.sv =====
// Controller of the disk erosion window: sequences accept, check, window
// scan and output. Depends on dew_pkg.
`default_nettype none
module dew_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire dew_pkg::t_stat i_stat,
    output dew_pkg::t_cmd      o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    logic [2:0] r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.store = 1'b1;
                    n_state     = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.win_ready) begin
                    o_cmd.scan_init = 1'b1;
                    n_state         = S_SCAN;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_stat.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/dew_datapath.sv =====
// Datapath of the disk erosion window: position counters, line store memory,
// window scan address generation, AND accumulator and output register.
// Depends on dew_pkg.
`default_nettype none
module dew_datapath (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire dew_pkg::t_cfg i_cfg,
    input  wire logic          i_restart,
    input  wire dew_pkg::t_cmd i_cmd,
    output dew_pkg::t_stat     o_stat,
    input  wire logic          i_command,
    input  wire logic [7:0]    i_pixel_in,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output logic [7:0]         o_pixel_out,
    output logic               o_end_of_row,
    output logic               o_end_of_frame
);

    localparam int CB = dew_pkg::COL_BITS;
    localparam int RB = dew_pkg::ROW_BITS;
    localparam int RG = dew_pkg::RING_BITS;

    logic [7:0] mem [dew_pkg::DEPTH];

    logic [RB:0]   r_in_row;
    logic [CB-1:0] r_in_col;
    logic          r_in_full;
    logic [RB-1:0] r_out_row;
    logic [CB-1:0] r_out_col;
    logic signed [4:0] r_dy, r_dx;
    logic          r_pv, r_pz;
    logic [7:0]    r_rdata, r_acc;

    logic [10:0] w_m1, h_m1, rmax, cmax, orow_r, ocol_r;
    logic        eor, eof, do_store, last_col;
    logic signed [4:0]  rad_s;
    logic signed [12:0] pos_r, pos_c;
    logic        outside, inside_disk;
    logic [7:0]  dist2, lim2;
    logic [RB-1:0] mr;
    logic [CB-1:0] mc;
    logic [dew_pkg::ADDR_BITS-1:0] waddr, raddr;

    function automatic logic [12:0] mirror(input logic signed [12:0] i,
                                           input logic [10:0] n);
        logic signed [12:0] v;
        logic signed [12:0] ns;
        ns = $signed({2'b00, n});
        v  = i;
        if (v < 0) begin
            v = -v;
        end else if (v >= ns) begin
            v = 13'sd2 * (ns - 13'sd1) - v;
        end
        if (v < 0) begin
            v = 13'sd0;
        end
        if (v > ns - 13'sd1) begin
            v = ns - 13'sd1;
        end
        return v;
    endfunction

    assign w_m1   = i_cfg.width - 11'd1;
    assign h_m1   = i_cfg.height - 11'd1;
    assign orow_r = {1'b0, r_out_row} + {8'd0, i_cfg.radius};
    assign ocol_r = {1'b0, r_out_col} + {8'd0, i_cfg.radius};
    assign rmax   = (orow_r < h_m1) ? orow_r : h_m1;
    assign cmax   = (ocol_r < w_m1) ? ocol_r : w_m1;

    assign o_stat.win_ready = r_in_full || (r_in_row > rmax) ||
                              ((r_in_row == rmax) && ({1'b0, r_in_col} > cmax));
    assign rad_s            = $signed({2'b00, i_cfg.radius});
    assign o_stat.scan_last = (r_dy == rad_s) && (r_dx == rad_s);
    assign o_stat.out_free  = !o_out_valid || i_out_ready;

    assign eor = ({1'b0, r_out_col} == w_m1);
    assign eof = eor && ({1'b0, r_out_row} == h_m1);

    // Window position of the current scan step.
    assign pos_r = $signed({3'b000, r_out_row}) + {{8{r_dy[4]}}, r_dy};
    assign pos_c = $signed({3'b000, r_out_col}) + {{8{r_dx[4]}}, r_dx};
    assign outside = (pos_r < 0) || (pos_r >= $signed({2'b00, i_cfg.height})) ||
                     (pos_c < 0) || (pos_c >= $signed({2'b00, i_cfg.width}));
    assign dist2 = 8'(r_dx * r_dx) + 8'(r_dy * r_dy);
    assign lim2  = 8'(i_cfg.radius * i_cfg.radius) + {5'd0, i_cfg.radius};
    assign inside_disk = (i_cfg.radius == 3'd0) ? ((r_dx == 0) && (r_dy == 0))
                                                : (dist2 < lim2);
    assign mr    = RB'(mirror(pos_r, i_cfg.height));
    assign mc    = CB'(mirror(pos_c, i_cfg.width));
    assign raddr = {mr[RG-1:0], mc};
    assign waddr = {r_in_row[RG-1:0], r_in_col};

    assign do_store = i_cmd.store && !i_command && !r_in_full;
    assign last_col = ({1'b0, r_in_col} == w_m1);

    always_ff @(posedge i_clk) begin
        if (do_store) begin
            mem[waddr] <= i_pixel_in;
        end
        r_rdata <= mem[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_row    <= '0;
            r_in_col    <= '0;
            r_in_full   <= 1'b0;
            r_out_row   <= '0;
            r_out_col   <= '0;
            r_pv        <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            // A new word may replace the one leaving in the same cycle.
            if (i_cmd.emit && !i_restart) begin
                o_out_valid <= 1'b1;
            end else if (o_out_valid && i_out_ready) begin
                o_out_valid <= 1'b0;
            end
            r_pv <= i_cmd.scan_step && inside_disk;
            r_pz <= outside && i_cfg.zero_fill;
            if (i_restart) begin
                r_in_row  <= '0;
                r_in_col  <= '0;
                r_in_full <= 1'b0;
                r_out_row <= '0;
                r_out_col <= '0;
            end else begin
                if (do_store) begin
                    if (last_col) begin
                        r_in_col <= '0;
                        r_in_row <= r_in_row + 1'b1;
                        if ((r_in_row + 1'b1) >= i_cfg.height) begin
                            r_in_full <= 1'b1;
                        end
                    end else begin
                        r_in_col <= r_in_col + 1'b1;
                    end
                end
                if (i_cmd.emit) begin
                    if (eof) begin
                        r_in_row  <= '0;
                        r_in_col  <= '0;
                        r_in_full <= 1'b0;
                        r_out_row <= '0;
                        r_out_col <= '0;
                    end else if (eor) begin
                        r_out_col <= '0;
                        r_out_row <= r_out_row + 1'b1;
                    end else begin
                        r_out_col <= r_out_col + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_init) begin
            r_dy  <= -rad_s;
            r_dx  <= -rad_s;
            r_acc <= 8'hFF;
        end else begin
            if (i_cmd.scan_step) begin
                if (r_dx == rad_s) begin
                    r_dx <= -rad_s;
                    r_dy <= r_dy + 5'sd1;
                end else begin
                    r_dx <= r_dx + 5'sd1;
                end
            end
            if (r_pv) begin
                r_acc <= r_pz ? 8'h00 : (r_acc & r_rdata);
            end
        end
        if (i_cmd.emit) begin
            o_pixel_out    <= r_acc;
            o_end_of_row   <= eor;
            o_end_of_frame <= eof;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/disk_erosion_window.sv =====
// Top level of the disk erosion window: configuration registers on an APB-style
// port, and the controller and datapath. Depends on dew_pkg, dew_ctrl, dew_datapath.
//
// Use: pixels of one image component enter in raster order as words on the
// input channel (i_in_valid / o_in_ready); a word with i_command high is a
// drain tick that carries no pixel. Each output word on o_out_valid /
// i_out_ready carries the AND of every pixel under a disk of the configured
// radius, with end-of-row and end-of-frame flags. Outputs lag the inputs by
// about radius rows and radius pixels; drain ticks flush the outputs still owed.
// Each input word that yields an output starts a window scan: the window is
// read one pixel a cycle through the single read port of the line store, and
// no new input word is taken until that output is emitted. When the receiver
// stalls, the finished word waits in the output register and the block still
// accepts the next input word, holding its own output in a wait state until the
// register frees. Reset restores radius 1, mirror padding and a 1024 by 1024
// frame and restarts the frame counters; the line store is not cleared.
// Any configuration write restarts the frame.
`default_nettype none
module disk_erosion_window (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic        i_command,
    input  wire logic [7:0]  i_pixel_in,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [7:0]       o_pixel_out,
    output logic             o_end_of_row,
    output logic             o_end_of_frame,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [2:0]  r_radius;
    logic        r_zero_fill;
    logic [10:0] r_width, r_height;
    logic        wr;
    dew_pkg::t_cfg  cfg;
    dew_pkg::t_cmd  cmd;
    dew_pkg::t_stat stat;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius    <= 3'd1;
            r_zero_fill <= 1'b0;
            r_width     <= 11'd1024;
            r_height    <= 11'd1024;
        end else if (wr) begin
            case (paddr[3:2])
                dew_pkg::REG_RADIUS:    r_radius    <= pwdata[2:0];
                dew_pkg::REG_ZERO_FILL: r_zero_fill <= pwdata[0];
                dew_pkg::REG_WIDTH:     r_width     <= pwdata[10:0];
                dew_pkg::REG_HEIGHT:    r_height    <= pwdata[10:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            dew_pkg::REG_RADIUS:    prdata = {29'd0, r_radius};
            dew_pkg::REG_ZERO_FILL: prdata = {31'd0, r_zero_fill};
            dew_pkg::REG_WIDTH:     prdata = {21'd0, r_width};
            dew_pkg::REG_HEIGHT:    prdata = {21'd0, r_height};
            default:                prdata = '0;
        endcase
    end

    // Sizes outside the supported range are clamped into it.
    always_comb begin
        cfg.radius    = r_radius;
        cfg.zero_fill = r_zero_fill;
        if (r_width == 11'd0) begin
            cfg.width = 11'd1;
        end else if (r_width > 11'(dew_pkg::MAX_WIDTH)) begin
            cfg.width = 11'(dew_pkg::MAX_WIDTH);
        end else begin
            cfg.width = r_width;
        end
        if (r_height == 11'd0) begin
            cfg.height = 11'd1;
        end else if (r_height > 11'(dew_pkg::MAX_HEIGHT)) begin
            cfg.height = 11'(dew_pkg::MAX_HEIGHT);
        end else begin
            cfg.height = r_height;
        end
    end

    dew_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    dew_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_restart      (wr),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_command      (i_command),
        .i_pixel_in     (i_pixel_in),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_pixel_out    (o_pixel_out),
        .o_end_of_row   (o_end_of_row),
        .o_end_of_frame (o_end_of_frame)
    );

endmodule
`default_nettype wire

// ===== tb/sv/dew_checker.sv =====
// Checker for the disk erosion window: watches the register port and both word
// channels, predicts every eroded pixel and compares it with the block's output.
// Depends on dew_pkg.
`default_nettype none
module dew_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_ready,
    input  wire logic        i_command,
    input  wire logic [7:0]  i_pixel_in,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_ready,
    input  wire logic [7:0]  i_pixel_out,
    input  wire logic        i_end_of_row,
    input  wire logic        i_end_of_frame,
    input  wire logic        i_psel,
    input  wire logic        i_penable,
    input  wire logic        i_pwrite,
    input  wire logic [3:0]  i_paddr,
    input  wire logic [31:0] i_pwdata,
    input  wire logic        i_pready,
    output int               o_errors,
    output int               o_pending,
    output int               o_frames,
    output int               o_results
);

    typedef struct packed {
        logic [7:0] px;
        logic       eor;
        logic       eof;
    } t_eroded;

    t_eroded     eroded_q[$];
    logic [7:0]  pixel_ring [dew_pkg::DEPTH];
    logic [2:0]  radius_r;
    logic        zero_fill_r;
    logic [10:0] width_r;
    logic [10:0] height_r;
    int          in_row, in_col, out_row, out_col;
    bit          in_full;

    initial begin
        o_errors  = 0;
        o_pending = 0;
        o_frames  = 0;
        o_results = 0;
        for (int k = 0; k < dew_pkg::DEPTH; k++) pixel_ring[k] = 8'd0;
    end

    function automatic int clamp_int(int v, int lo, int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Mirror without repeating the edge, then clamp for windows wider than the image.
    function automatic int fold_index(int i, int n);
        if (i < 0) i = -i;
        else if (i >= n) i = 2 * (n - 1) - i;
        return clamp_int(i, 0, n - 1);
    endfunction

    task automatic restart_frame();
        in_row  = 0;
        in_col  = 0;
        out_row = 0;
        out_col = 0;
        in_full = 0;
    endtask

    task automatic apply_write(logic [1:0] idx, logic [31:0] d);
        case (idx)
            dew_pkg::REG_RADIUS: begin
                radius_r = d[2:0];
            end
            dew_pkg::REG_ZERO_FILL: begin
                zero_fill_r = d[0];
            end
            dew_pkg::REG_WIDTH: begin
                width_r = d[10:0];
            end
            dew_pkg::REG_HEIGHT: begin
                height_r = d[10:0];
            end
            default: begin
            end
        endcase
        restart_frame();
    endtask

    task automatic predict_word(logic cmd, logic [7:0] px);
        int      w, h, r, rmax, cmax, rr, cc;
        bit      ready, outside;
        t_eroded e;
        w = clamp_int(int'(width_r), 1, dew_pkg::MAX_WIDTH);
        h = clamp_int(int'(height_r), 1, dew_pkg::MAX_HEIGHT);
        r = clamp_int(int'(radius_r), 0, dew_pkg::MAX_RADIUS);
        // A pixel is stored only while the frame still takes input; otherwise it
        // behaves as a drain tick.
        if (!cmd && !in_full) begin
            pixel_ring[(in_row % dew_pkg::LINE_ROWS) * dew_pkg::MAX_WIDTH + in_col] = px;
            in_col++;
            if (in_col >= w) begin
                in_col = 0;
                in_row++;
                if (in_row >= h) in_full = 1;
            end
        end
        rmax  = (out_row + r < h - 1) ? out_row + r : h - 1;
        cmax  = (out_col + r < w - 1) ? out_col + r : w - 1;
        ready = in_full || in_row > rmax || (in_row == rmax && in_col > cmax);
        if (!ready) return;
        e.px = 8'hFF;
        for (int dy = -r; dy <= r; dy++) begin
            for (int dx = -r; dx <= r; dx++) begin
                if (r == 0 ? (dx != 0 || dy != 0) : (dx * dx + dy * dy >= r * r + r))
                    continue;
                rr = out_row + dy;
                cc = out_col + dx;
                outside = rr < 0 || rr >= h || cc < 0 || cc >= w;
                if (outside && zero_fill_r) begin
                    e.px = 8'h00;
                end else begin
                    if (outside) begin
                        rr = fold_index(rr, h);
                        cc = fold_index(cc, w);
                    end
                    e.px &= pixel_ring[(rr % dew_pkg::LINE_ROWS) * dew_pkg::MAX_WIDTH + cc];
                end
            end
        end
        e.eor = (out_col == w - 1);
        e.eof = e.eor && (out_row == h - 1);
        eroded_q = {eroded_q, e};
        if (e.eof) begin
            restart_frame();
            o_frames++;
        end else if (e.eor) begin
            out_col = 0;
            out_row++;
        end else begin
            out_col++;
        end
    endtask

    task automatic report_mismatch(string field, int got, int want);
        $display("mismatch in %s of output word %0d: got %0d, expected %0d",
                 field, o_results, got, want);
        o_errors++;
    endtask

    always @(posedge i_clk) begin
        t_eroded e;
        if (!i_rst_n) begin
            radius_r    = 3'd1;
            zero_fill_r = 1'b0;
            width_r     = 11'd1024;
            height_r    = 11'd1024;
            restart_frame();
            eroded_q.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready)
                apply_write(i_paddr[3:2], i_pwdata);
            if (i_in_valid && i_in_ready)
                predict_word(i_command, i_pixel_in);
            if (i_out_valid && i_out_ready) begin
                if (eroded_q.size() == 0) begin
                    report_mismatch("presence", 1, 0);
                end else begin
                    e = eroded_q.pop_front();
                    if (i_pixel_out !== e.px) report_mismatch("pixel", i_pixel_out, e.px);
                    if (i_end_of_row !== e.eor)
                        report_mismatch("end of row", i_end_of_row, e.eor);
                    if (i_end_of_frame !== e.eof)
                        report_mismatch("end of frame", i_end_of_frame, e.eof);
                end
                o_results++;
            end
        end
        o_pending = eroded_q.size();
    end

endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Top of the disk erosion window testbench: clock, reset, register writes and
// word stimulus, and the verdict. Depends on dew_pkg, dew_checker and the block.
`default_nettype none
module testbench;

    localparam int CYCLE_LIMIT  = 4000000;
    localparam int SETTLE       = 300;  // longer than the slowest window scan
    localparam int HOLD_CYCLES  = 400;
    localparam int RANDOM_WORDS = 300;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        i_command = 1'b0;
    logic [7:0]  i_pixel_in = 8'd0;
    logic        i_out_ready = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = 4'd0;
    logic [31:0] pwdata = 32'd0;
    logic        o_in_ready, o_out_valid, o_end_of_row, o_end_of_frame, pready;
    logic [7:0]  o_pixel_out;
    logic [31:0] prdata;

    int errors, pending, frames, results;
    int cycles = 0;
    int words_sent = 0;
    int settings_run = 0;
    bit calm = 0;      // no idling on either side while set
    bit hold_req = 0;  // asks the receiver for one long hold-off
    int hold_left = 0;

    always #6 i_clk = ~i_clk;

    disk_erosion_window u_top (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_ready, .i_command, .i_pixel_in,
        .o_out_valid, .i_out_ready, .o_pixel_out, .o_end_of_row, .o_end_of_frame,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    dew_checker u_checker (
        .i_clk, .i_rst_n, .i_in_valid, .i_in_ready(o_in_ready), .i_command,
        .i_pixel_in, .i_out_valid(o_out_valid), .i_out_ready,
        .i_pixel_out(o_pixel_out), .i_end_of_row(o_end_of_row),
        .i_end_of_frame(o_end_of_frame), .i_psel(psel), .i_penable(penable),
        .i_pwrite(pwrite), .i_paddr(paddr), .i_pwdata(pwdata), .i_pready(pready),
        .o_errors(errors), .o_pending(pending), .o_frames(frames), .o_results(results)
    );

    // Watchdog: a run that hangs is a failure.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles with %0d words outstanding", cycles, pending);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // The receiver stalls at random. On request it holds off for a long stretch,
    // counted here, so that the output register fills and the input stalls.
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_req  = 0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            i_out_ready = 1'b0;
            hold_left--;
        end else begin
            i_out_ready = calm || $urandom_range(99) >= 11;
        end
    end

    // All tasks below are entered and left at a falling edge.
    task automatic apb_write(logic [1:0] idx, logic [31:0] d);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = {idx, 2'b00};
        pwdata  = d;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic send_word(logic cmd, logic [7:0] px);
        while (!calm && $urandom_range(99) < 11) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_command  = cmd;
        i_pixel_in = px;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        @(negedge i_clk);
        words_sent++;
    endtask

    // Wait until every predicted word has come out, then let a window scan finish.
    task automatic settle();
        i_in_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    // Mostly bright pixels with single dark bits, so that erosion keeps detail.
    function automatic logic [7:0] rand_pixel();
        case ($urandom_range(3))
            0: return 8'($urandom);
            1: return 8'hFF;
            default: return 8'hFF ^ (8'd1 << $urandom_range(7));
        endcase
    endfunction

    // One setting: write all four registers, feed a frame with drain ticks mixed
    // in, and drain it until the end-of-frame word has been predicted. A partial
    // frame stops early and is cut off by the next register write.
    task automatic run_frame(int r, int zp, int w, int h, int stop_at = -1);
        int count, f0;
        settle();
        apb_write(dew_pkg::REG_RADIUS, r);
        apb_write(dew_pkg::REG_ZERO_FILL, zp);
        apb_write(dew_pkg::REG_WIDTH, w);
        apb_write(dew_pkg::REG_HEIGHT, h);
        settings_run++;
        w     = (w < 1) ? 1 : ((w > dew_pkg::MAX_WIDTH) ? dew_pkg::MAX_WIDTH : w);
        h     = (h < 1) ? 1 : ((h > dew_pkg::MAX_HEIGHT) ? dew_pkg::MAX_HEIGHT : h);
        count = (stop_at >= 0) ? stop_at : w * h;
        f0    = frames;
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(9) == 0) send_word(1'b1, 8'($urandom));
            send_word(1'b0, rand_pixel());
        end
        if (stop_at >= 0) return;
        // Pixels offered while outputs are still owed must be dropped.
        while (frames == f0)
            send_word($urandom_range(5) == 0 ? 1'b0 : 1'b1, 8'($urandom));
    endtask

    initial begin
        int r, w, h, n;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed part. Two pixels under the reset setting give no output.
        send_word(1'b0, 8'hFF);
        send_word(1'b0, 8'h00);
        settle();
        // Widest writes to every size bit, cut off by the next setting.
        apb_write(dew_pkg::REG_WIDTH, 32'h7FF);
        apb_write(dew_pkg::REG_HEIGHT, 32'h7FF);
        run_frame(0, 0, 1, 1);              // single pixel, centre-only window
        run_frame(7, 0, 0, 0);              // zero sizes clamp; mirror clamped
        run_frame(7, 1, 3, 2);              // window wider than the image, zeros
        run_frame(2, 0, 4, 3);
        run_frame(1, 1, 3, 3, 4);           // frame restarted by a write

        // Random part: mostly small frames, with the calm stretch and the long
        // receiver hold-off always included.
        n = 0;
        while (words_sent < RANDOM_WORDS || n < 10) begin
            r = ($urandom_range(9) < 2) ? 7 : $urandom_range(3);
            w = $urandom_range(12, 1);
            h = $urandom_range(10, 1);
            calm = (n >= 6 && n < 10);
            if (n == 3) begin
                hold_req = 1;
                run_frame(1, $urandom_range(1), 12, 10);
            end else if ($urandom_range(4) == 0) begin
                run_frame(r, $urandom_range(1), w, h, $urandom_range(w * h - 1));
            end else begin
                run_frame(r, $urandom_range(1), w, h);
            end
            n++;
        end
        calm = 0;
        run_frame(1, 1, 2047, 1);           // widest row, clamped
        run_frame(7, 0, 1, 2047, 40);       // tall column with the widest disk, cut short

        settle();
        $display("Covered %0d accepted words over %0d settings: %0d frames, %0d words checked.",
                 words_sent, settings_run, frames, results);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
`default_nettype wire
